// ===== src/sorted_interval_set_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted interval set unit: assertion macros
// Clocked property wrappers used by the checker of this block.
// ----------------------------------------------------------------------------
`ifndef SORTED_INTERVAL_SET_UNIT_MACROS_SVH
`define SORTED_INTERVAL_SET_UNIT_MACROS_SVH

// checked outside reset
`define SIS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define SIS_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted interval set package
// Widths, codes and state encoding shared by the unit and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

  localparam int OFF_W             = 63;
  localparam int CMD_W             = 2;
  localparam int KIND_W            = 3;
  localparam int CNT_OUT_W         = 5;
  localparam int MAX_INTERVALS_DEF = 16;

  typedef logic [OFF_W-1:0] offset_t;

  localparam offset_t INF_OFFSET = {OFF_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SCAN   = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE          = 3'd0,
    KIND_EQUAL         = 3'd1,
    KIND_CONTAINS      = 3'd2,
    KIND_CONTAINED     = 3'd3,
    KIND_STARTS_BEFORE = 3'd4,
    KIND_ENDS_AFTER    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EVAL2,
    ST_FINISH,
    ST_RESPOND
  } state_t;

endpackage

`default_nettype wire

// ===== src/sorted_interval_set_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted interval set unit
// Sorted table of disjoint inclusive offset intervals with add, remove, scan.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries command, lo_offset and
//   hi_offset. Response channel (rsp_valid/rsp_ready) returns one response per
//   request: overlap_kind, hit_lo, hit_hi, entries_in_use and table_full.
//   One request is processed at a time; req_ready is high only when idle.
//   The unit walks the held entries in turn over the entry memory, which has
//   one read and one write port: ST_READ reads an entry, ST_EVAL evaluates
//   it and writes its result, and ST_EVAL2 adds a second write when one entry
//   yields two table writes (an add placed before an entry, or a split on
//   remove). ST_FINISH then registers the response and ST_RESPOND offers it.
//   An empty table or a reversed or unused request skips the walk and goes
//   straight to ST_FINISH. Results are built in the spare bank of the memory
//   and committed by flipping the bank bit. Reset empties the table at once;
//   no clearing pass is needed. A stalled receiver holds the response
//   registered; no new request is taken until it is delivered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_interval_set_unit
  import sis_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [OFF_W-1:0]     lo_offset,
  input  wire logic [OFF_W-1:0]     hi_offset,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output logic [KIND_W-1:0]         overlap_kind,
  output logic [OFF_W-1:0]          hit_lo,
  output logic [OFF_W-1:0]          hit_hi,
  output logic [CNT_OUT_W-1:0]      entries_in_use,
  output logic                      table_full
);

  localparam int IW    = $clog2(MAX_INTERVALS);
  localparam int AW    = IW + 1;
  localparam int CW    = $clog2(MAX_INTERVALS + 1);
  localparam int NW    = $clog2(MAX_INTERVALS + 2);
  localparam int DEPTH = 1 << AW;

  state_t          state, state_next;
  cmd_t            op;
  logic            act;
  offset_t         org_lo, org_hi, acc_lo, acc_hi;
  offset_t         p_lo, p_hi;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [NW-1:0]   n;
  logic            bank;
  logic            placed, found, stop;
  kind_t           kind;
  offset_t         hlo, hhi;

  offset_t         mem_lo [DEPTH];
  offset_t         mem_hi [DEPTH];
  offset_t         rd_lo, rd_hi;
  logic [AW-1:0]   raddr, waddr;
  logic            we;
  offset_t         wlo, whi;

  logic            left, right, outside, cut_l, cut_r, last, room;
  logic            w0_en, w1_en;
  offset_t         w0_lo, w0_hi, w1_lo, w1_hi;
  logic [NW-1:0]   n_fin;
  logic            full_c, commit_c;
  kind_t           kind_c;

  assign raddr = {bank, idx[IW-1:0]};
  assign waddr = {~bank, n[IW-1:0]};
  assign last  = (idx == count - CW'(1));
  assign room  = (n < NW'(MAX_INTERVALS));

  always_ff @(posedge clk) begin
    if (we) begin
      mem_lo[waddr] <= wlo;
      mem_hi[waddr] <= whi;
    end
    rd_lo <= mem_lo[raddr];
    rd_hi <= mem_hi[raddr];
  end

  // per-entry evaluation of the shared compare unit
  always_comb begin
    left    = (acc_lo != '0) && (rd_hi < acc_lo - OFF_W'(1));
    right   = (acc_hi != INF_OFFSET) && (rd_lo > acc_hi + OFF_W'(1));
    outside = (rd_hi < org_lo) || (rd_lo > org_hi);
    cut_l   = rd_lo < org_lo;
    cut_r   = rd_hi > org_hi;
    w0_en   = 1'b0;
    w1_en   = 1'b0;
    w0_lo   = rd_lo;
    w0_hi   = rd_hi;
    w1_lo   = rd_lo;
    w1_hi   = rd_hi;
    case (op)
      CMD_ADD: begin
        if (left || right) begin
          w0_en = 1'b1;
          if (right && !placed) begin
            w0_lo = acc_lo;
            w0_hi = acc_hi;
            w1_en = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if (outside) begin
          w0_en = 1'b1;
        end else if (cut_l) begin
          w0_en = 1'b1;
          w0_hi = org_lo - OFF_W'(1);
          w1_en = cut_r;
          w1_lo = org_hi + OFF_W'(1);
        end else if (cut_r) begin
          w0_en = 1'b1;
          w0_lo = org_hi + OFF_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (rd_lo == org_lo && rd_hi == org_hi) begin
      kind_c = KIND_EQUAL;
    end else if (rd_lo <= org_lo && org_hi != INF_OFFSET && rd_hi >= org_hi) begin
      kind_c = KIND_CONTAINS;
    end else if (org_lo <= rd_lo && rd_hi <= org_hi) begin
      kind_c = KIND_CONTAINED;
    end else if (rd_lo < org_lo) begin
      kind_c = KIND_STARTS_BEFORE;
    end else begin
      kind_c = KIND_ENDS_AFTER;
    end

    n_fin    = n + NW'(act && op == CMD_ADD && !placed);
    full_c   = act && (op == CMD_ADD || op == CMD_REMOVE) &&
               (n_fin > NW'(MAX_INTERVALS));
    commit_c = act && (op == CMD_ADD || op == CMD_REMOVE) && !full_c;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (command <= CMD_SCAN && lo_offset <= hi_offset && count != '0) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_READ:    state_next = ST_EVAL;
      ST_EVAL: begin
        if (w1_en) begin
          state_next = ST_EVAL2;
        end else if (last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_EVAL2:   state_next = last ? ST_FINISH : ST_READ;
      ST_FINISH:  state_next = ST_RESPOND;
      ST_RESPOND: state_next = rsp_ready ? ST_IDLE : ST_RESPOND;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
    rsp_valid = (state == ST_RESPOND);
    we        = 1'b0;
    wlo       = w0_lo;
    whi       = w0_hi;
    case (state)
      ST_EVAL:   we = w0_en && room;
      ST_EVAL2: begin
        we  = room;
        wlo = p_lo;
        whi = p_hi;
      end
      ST_FINISH: begin
        we  = act && op == CMD_ADD && !placed && room;
        wlo = acc_lo;
        whi = acc_hi;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      bank  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            op     <= cmd_t'(command);
            act    <= (command <= CMD_SCAN) && (lo_offset <= hi_offset);
            org_lo <= lo_offset;
            org_hi <= hi_offset;
            acc_lo <= lo_offset;
            acc_hi <= hi_offset;
            idx    <= '0;
            n      <= '0;
            placed <= 1'b0;
            found  <= 1'b0;
            stop   <= 1'b0;
            kind   <= KIND_NONE;
            hlo    <= '0;
            hhi    <= '0;
          end
        end
        ST_EVAL: begin
          if (!found && !stop && rd_hi >= org_lo) begin
            if (rd_lo > org_hi) begin
              stop <= 1'b1;
            end else begin
              found <= 1'b1;
              kind  <= kind_c;
              hlo   <= rd_lo;
              hhi   <= rd_hi;
            end
          end
          if (op == CMD_ADD && !(left || right)) begin
            if (rd_lo < acc_lo) acc_lo <= rd_lo;
            if (rd_hi > acc_hi) acc_hi <= rd_hi;
          end
          if (op == CMD_ADD && w1_en) placed <= 1'b1;
          if (w0_en && n <= NW'(MAX_INTERVALS)) n <= n + NW'(1);
          p_lo <= w1_lo;
          p_hi <= w1_hi;
          if (!w1_en) idx <= idx + CW'(1);
        end
        ST_EVAL2: begin
          if (n <= NW'(MAX_INTERVALS)) n <= n + NW'(1);
          idx <= idx + CW'(1);
        end
        ST_FINISH: begin
          overlap_kind   <= kind;
          hit_lo         <= hlo;
          hit_hi         <= hhi;
          table_full     <= full_c;
          entries_in_use <= commit_c ? CNT_OUT_W'(n_fin) : CNT_OUT_W'(count);
          if (commit_c) begin
            bank  <= ~bank;
            count <= CW'(n_fin);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/sis_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted interval set checker
// Port-level properties of the unit, bound into every instance of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_interval_set_unit_macros.svh"

module sis_checker
  import sis_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 req_valid,
  input wire logic                 req_ready,
  input wire logic [CMD_W-1:0]     command,
  input wire logic [OFF_W-1:0]     lo_offset,
  input wire logic [OFF_W-1:0]     hi_offset,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic [KIND_W-1:0]    overlap_kind,
  input wire logic [OFF_W-1:0]     hit_lo,
  input wire logic [OFF_W-1:0]     hit_hi,
  input wire logic [CNT_OUT_W-1:0] entries_in_use,
  input wire logic                 table_full
);

  `SIS_ASSERT_ALL(a_reset_quiet, rst |=> !rsp_valid, "response valid right after reset")
  `SIS_ASSERT_RUN(a_one_at_a_time, !(req_ready && rsp_valid), "request taken while responding")
  `SIS_ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_lo), "response dropped")
  `SIS_ASSERT_RUN(a_kind_range, rsp_valid |-> overlap_kind <= KIND_ENDS_AFTER, "bad overlap kind")
  `SIS_ASSERT_RUN(a_miss_zero, rsp_valid && overlap_kind == KIND_NONE |-> hit_lo == '0 && hit_hi == '0, "miss with bounds")

endmodule

bind sorted_interval_set_unit sis_checker u_sis_checker (.*);

`default_nettype wire

// ===== sim/sorted_interval_set_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted interval set checker
// Watches the request and response channels, keeps its own copy of the
// interval table, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_interval_set_checker
  import sis_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [OFF_W-1:0]     lo_offset,
  input  logic [OFF_W-1:0]     hi_offset,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  logic [KIND_W-1:0]    overlap_kind,
  input  logic [OFF_W-1:0]     hit_lo,
  input  logic [OFF_W-1:0]     hit_hi,
  input  logic [CNT_OUT_W-1:0] entries_in_use,
  input  logic                 table_full,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    kind_t                kind;
    offset_t              lo;
    offset_t              hi;
    logic [CNT_OUT_W-1:0] used;
    logic                 full;
  } response_t;

  offset_t   span_lo [MAX_INTERVALS];
  offset_t   span_hi [MAX_INTERVALS];
  int        span_cnt;
  offset_t   next_lo [MAX_INTERVALS+2];
  offset_t   next_hi [MAX_INTERVALS+2];
  response_t awaited_rsp [$];

  function automatic void install(int n);
    for (int i = 0; i < n; i++) begin
      span_lo[i] = next_lo[i];
      span_hi[i] = next_hi[i];
    end
    span_cnt = n;
  endfunction

  function automatic bit merge_span(offset_t lo, offset_t hi);
    int n;
    bit placed;
    bit left, right;
    n = 0;
    placed = 0;
    for (int i = 0; i < span_cnt; i++) begin
      left  = (lo != 0) && (span_hi[i] < lo - 1);
      right = (hi != INF_OFFSET) && (span_lo[i] > hi + 1);
      if (left || right) begin
        if (right && !placed) begin
          next_lo[n] = lo; next_hi[n] = hi; n++; placed = 1;
        end
        next_lo[n] = span_lo[i]; next_hi[n] = span_hi[i]; n++;
      end else begin
        if (span_lo[i] < lo) lo = span_lo[i];
        if (span_hi[i] > hi) hi = span_hi[i];
      end
    end
    if (!placed) begin
      next_lo[n] = lo; next_hi[n] = hi; n++;
    end
    if (n > MAX_INTERVALS) return 1;
    install(n);
    return 0;
  endfunction

  function automatic bit carve_span(offset_t lo, offset_t hi);
    int n;
    n = 0;
    for (int i = 0; i < span_cnt; i++) begin
      if (n > MAX_INTERVALS) return 1;
      if (span_hi[i] < lo || span_lo[i] > hi) begin
        next_lo[n] = span_lo[i]; next_hi[n] = span_hi[i]; n++;
      end else begin
        if (span_lo[i] < lo) begin
          next_lo[n] = span_lo[i]; next_hi[n] = lo - 1; n++;
        end
        if (span_hi[i] > hi) begin
          next_lo[n] = hi + 1; next_hi[n] = span_hi[i]; n++;
        end
      end
    end
    if (n > MAX_INTERVALS) return 1;
    install(n);
    return 0;
  endfunction

  function automatic response_t apply_request(logic [CMD_W-1:0] cmd, offset_t lo,
                                              offset_t hi);
    response_t r;
    offset_t a, b;
    r = '0;
    r.kind = KIND_NONE;
    if (cmd != 2'd3 && lo <= hi) begin
      for (int i = 0; i < span_cnt; i++) begin
        a = span_lo[i];
        b = span_hi[i];
        if (b < lo) continue;
        if (a > hi) break;
        r.lo = a;
        r.hi = b;
        if (a == lo && b == hi) r.kind = KIND_EQUAL;
        else if (a <= lo && hi != INF_OFFSET && b >= hi) r.kind = KIND_CONTAINS;
        else if (lo <= a && b <= hi) r.kind = KIND_CONTAINED;
        else if (a < lo) r.kind = KIND_STARTS_BEFORE;
        else r.kind = KIND_ENDS_AFTER;
        break;
      end
      if (cmd == CMD_ADD) r.full = merge_span(lo, hi);
      else if (cmd == CMD_REMOVE) r.full = carve_span(lo, hi);
    end
    r.used = span_cnt[CNT_OUT_W-1:0];
    return r;
  endfunction

  assign pending = awaited_rsp.size();

  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      span_cnt <= 0;
      fail_count <= 0;
      awaited_rsp.delete();
    end else begin
      if (req_valid && req_ready)
        awaited_rsp.push_back(apply_request(command, lo_offset, hi_offset));
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: response with none expected: kind %0d", $time, overlap_kind);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_rsp.pop_front();
          if (overlap_kind !== want.kind || hit_lo !== want.lo || hit_hi !== want.hi ||
              entries_in_use !== want.used || table_full !== want.full) begin
            $display("%0t: expected kind %0d lo %h hi %h used %0d full %0b", $time,
                     want.kind, want.lo, want.hi, want.used, want.full);
            $display("%0t: actual   kind %0d lo %h hi %h used %0d full %0b", $time,
                     overlap_kind, hit_lo, hit_hi, entries_in_use, table_full);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted interval set testbench
// Drives directed and random add, remove, scan and unused-command requests with
// random stalls on both channels; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sis_pkg::*;

  localparam int LIMIT = 1000000;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  logic [CMD_W-1:0]     command;
  logic [OFF_W-1:0]     lo_offset;
  logic [OFF_W-1:0]     hi_offset;
  logic                 rsp_valid;
  logic                 rsp_ready;
  logic [KIND_W-1:0]    overlap_kind;
  logic [OFF_W-1:0]     hit_lo;
  logic [OFF_W-1:0]     hit_hi;
  logic [CNT_OUT_W-1:0] entries_in_use;
  logic                 table_full;
  int                   fail_count;
  int                   pending;
  int                   cycles;
  int                   stall_left;
  bit                   calm;

  sorted_interval_set_unit i_dut (.*);

  sorted_interval_set_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_ready <= 0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(7) == 0) begin
      rsp_ready <= 0;
      stall_left <= $urandom_range(5);
    end else begin
      rsp_ready <= 1;
    end
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, offset_t lo, offset_t hi);
    bit rdy;
    req_valid <= 1;
    command <= cmd;
    lo_offset <= lo;
    hi_offset <= hi;
    do begin
      @(negedge clk);
      rdy = req_ready;
      @(posedge clk);
    end while (!rdy);
    if (!calm && $urandom_range(5) == 0) begin
      req_valid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  function automatic offset_t wide_offset();
    return OFF_W'({$urandom, $urandom});
  endfunction

  task automatic random_request();
    logic [CMD_W-1:0] cmd;
    offset_t lo, hi;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) cmd = CMD_ADD;
    else if (pick < 70) cmd = CMD_REMOVE;
    else if (pick < 95) cmd = CMD_SCAN;
    else cmd = 2'd3;
    pick = $urandom_range(99);
    lo = offset_t'($urandom_range(200));
    hi = lo + offset_t'($urandom_range(12));
    if (pick < 8) hi = INF_OFFSET;
    else if (pick < 14) begin
      lo = wide_offset();
      hi = wide_offset();
    end else if (pick < 18) begin
      lo = INF_OFFSET - offset_t'($urandom_range(40));
      hi = INF_OFFSET - offset_t'($urandom_range(10));
    end else if (pick < 21) begin
      hi = offset_t'($urandom_range(200));
    end
    send_request(cmd, lo, hi);
  endtask

  initial begin
    rst = 1;
    req_valid = 0;
    command = CMD_SCAN;
    lo_offset = '0;
    hi_offset = '0;
    cycles = 0;
    calm = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_request(CMD_SCAN, 0, INF_OFFSET);
    send_request(CMD_ADD, 10, 20);
    send_request(CMD_ADD, 22, 30);
    send_request(CMD_ADD, 21, 21);
    send_request(CMD_SCAN, 10, 30);
    send_request(CMD_SCAN, 12, 14);
    send_request(CMD_SCAN, 5, 40);
    send_request(CMD_SCAN, 15, 40);
    send_request(CMD_SCAN, 5, 15);
    send_request(CMD_SCAN, 12, INF_OFFSET);
    send_request(CMD_REMOVE, 15, 16);
    send_request(CMD_REMOVE, 30, 10);
    send_request(2'd3, 0, 5);
    send_request(CMD_ADD, INF_OFFSET, INF_OFFSET);
    send_request(CMD_ADD, 0, 0);
    send_request(CMD_ADD, 2, 8);
    send_request(CMD_REMOVE, 0, INF_OFFSET);
    for (int k = 0; k < MAX_INTERVALS_DEF; k++)
      send_request(CMD_ADD, offset_t'(k * 4), offset_t'(k * 4 + 2));
    send_request(CMD_ADD, 1000, 1000);
    send_request(CMD_REMOVE, 5, 5);
    send_request(CMD_ADD, 3, 3);
    send_request(CMD_REMOVE, 0, INF_OFFSET);

    for (int n = 0; n < 2000; n++) begin
      if (n == 1000) begin
        req_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      if (n == 1800) calm = 1;
      random_request();
    end
    req_valid <= 0;
    @(posedge clk);

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
